// File: src/sfl_pkg.sv
// ----------------------------------------------------------------------------
// Slab free-list allocator package
// Shared widths, register indexes, request/result types and control commands.
// ----------------------------------------------------------------------------
package sfl_pkg;

    localparam int ADDR_W       = 48;
    localparam int SIZE_W       = 13;
    localparam int LOG2_W       = 4;
    localparam int FREE_COUNT_W = 10;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_LOG2  = 2'd1;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [LOG2_W-1:0] RESET_OBJ_LOG2 = 4'd3;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic [ADDR_W-1:0]       object_address;
        logic [FREE_COUNT_W-1:0] free_count;
    } rsp_t;

    typedef struct packed {
        logic accept;   // latch the request and read the head link
        logic exec;     // update the list and load the result
    } ctrl_cmd_t;

endpackage

// File: src/sfl_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sfl_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Two-state sequencer: accept a request, then execute it and strobe the result.
// ----------------------------------------------------------------------------
module sfl_ctrl
    import sfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output logic      cfg_ready,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;

endmodule

// File: src/sfl_datapath.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Configuration, free-list head state, link memory and result registers.
// ----------------------------------------------------------------------------
module sfl_datapath
    import sfl_pkg::*;
#(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_OBJECTS = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  req_t                   request,
    output rsp_t                   result
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int CMP_W = (OFF_W > CNT_W) ? OFF_W : CNT_W;
    localparam int LNK_W = IDX_W + 1;

    // Objects in the page for a given object size: one slot is reserved.
    function automatic logic [CNT_W-1:0] count_of(input logic [LOG2_W-1:0] lg);
        int slots;
        int n;
        slots = PAGE_BYTES >> lg;
        n     = (slots == 0) ? 0 : slots - 1;
        if (n > MAX_OBJECTS)
        begin
            n = MAX_OBJECTS;
        end
        return CNT_W'(n);
    endfunction

    localparam logic [CNT_W-1:0] RESET_COUNT = count_of(RESET_OBJ_LOG2);

    logic [ADDR_W-1:0] page_base_reg, page_base_next;
    logic [LOG2_W-1:0] log2_reg, log2_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              empty_reg, empty_next;
    logic [CNT_W-1:0]  untouched_reg, untouched_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    req_t              req_reg;
    rsp_t              result_reg, result_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LNK_W-1:0]  ram_wdata;
    logic [LNK_W-1:0]  ram_rdata;

    logic              size_ok;
    logic [CNT_W-1:0]  h_ext;
    logic [CNT_W-1:0]  h_plus1;
    logic [ADDR_W-1:0] alloc_addr;
    logic              in_page;
    logic [ADDR_W-1:0] offset;
    logic [OFF_W-1:0]  idx;
    logic [CMP_W-1:0]  idx_ext;
    logic              idx_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              cfg_hit;
    logic [LOG2_W-1:0] cfg_log2;

    sfl_ram #(
        .WIDTH (LNK_W),
        .DEPTH (MAX_OBJECTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Allocate side.
    assign size_ok    = ({3'b000, req_reg.request_size} == (16'd1 << log2_reg));
    assign h_ext      = CNT_W'(head_reg);
    assign h_plus1    = h_ext + CNT_W'(1);
    assign alloc_addr = page_base_reg + (ADDR_W'(head_reg) << log2_reg);

    // Free side: the offset must lie inside the page, low bits are dropped.
    assign offset   = req_reg.free_address - page_base_reg;
    assign in_page  = (req_reg.free_address >= page_base_reg) &&
                      (offset < ADDR_W'(PAGE_BYTES));
    assign idx      = offset[OFF_W-1:0] >> log2_reg;
    assign idx_ext  = CMP_W'(idx);
    assign idx_ok   = (idx_ext < CMP_W'(count_reg)) && (idx_ext < CMP_W'(untouched_reg));
    assign free_idx = idx_ext[IDX_W-1:0];

    assign cfg_hit  = cfg_we && ((cfg_index == CFG_PAGE_BASE) || (cfg_index == CFG_OBJ_LOG2));
    assign cfg_log2 = (cfg_index == CFG_OBJ_LOG2) ? cfg_data[LOG2_W-1:0] : log2_reg;

    always_comb
    begin
        page_base_next = page_base_reg;
        log2_next      = log2_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        untouched_next = untouched_reg;
        free_next      = free_reg;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = free_idx;
        ram_wdata      = {empty_reg, (empty_reg ? IDX_W'(0) : head_reg)};

        if (cfg_hit)
        begin
            // A write to either configuration register frees the whole page again.
            if (cfg_index == CFG_PAGE_BASE)
            begin
                page_base_next = cfg_data;
            end
            log2_next      = cfg_log2;
            count_next     = count_of(cfg_log2);
            head_next      = '0;
            untouched_next = '0;
            free_next      = count_of(cfg_log2);
            empty_next     = (count_of(cfg_log2) == '0);
        end
        else if (cmd.exec)
        begin
            result_next.ok             = 1'b0;
            result_next.object_address = '0;
            if (req_reg.kind == KIND_ALLOC)
            begin
                if (size_ok && !empty_reg)
                begin
                    if (h_ext >= untouched_reg)
                    begin
                        // Head sits in the untouched region: step to the next index.
                        untouched_next = h_plus1;
                        if (h_plus1 >= count_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = IDX_W'(h_plus1);
                        end
                    end
                    else if (!ram_rdata[IDX_W])
                    begin
                        head_next = ram_rdata[IDX_W-1:0];
                    end
                    else
                    begin
                        empty_next = 1'b1;
                    end
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - CNT_W'(1);
                    end
                    result_next.ok             = 1'b1;
                    result_next.object_address = alloc_addr;
                end
            end
            else
            begin
                if (in_page && idx_ok)
                begin
                    ram_we     = 1'b1;
                    head_next  = free_idx;
                    empty_next = 1'b0;
                    if (free_reg < count_reg)
                    begin
                        free_next = free_reg + CNT_W'(1);
                    end
                    result_next.ok = 1'b1;
                end
            end
            result_next.free_count = FREE_COUNT_W'(free_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_base_reg <= '0;
            log2_reg      <= RESET_OBJ_LOG2;
            count_reg     <= RESET_COUNT;
            head_reg      <= '0;
            empty_reg     <= (RESET_COUNT == '0);
            untouched_reg <= '0;
            free_reg      <= RESET_COUNT;
        end
        else
        begin
            page_base_reg <= page_base_next;
            log2_reg      <= log2_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            untouched_reg <= untouched_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// File: src/slab_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Slab free-list allocator
// Hands out and takes back equal-size objects of one page through a free list.
// ----------------------------------------------------------------------------
// A request is latched on acceptance and executed in the EXEC state; done then
// strobes with the registered result. A new request is taken only when idle, after
// the last one has executed; an allocate reads the next link from the synchronous
// link RAM before the head register can advance. Reset clears all control state at
// once; the whole page is free, no sweep. A configuration write re-initializes the free list.
module slab_free_list_allocator
    import sfl_pkg::*;
#(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_OBJECTS = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  req_t                   request,
    output logic                   done,
    output rsp_t                   result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    ctrl_cmd_t cmd;

    sfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    sfl_datapath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .result    (result)
    );

endmodule

// File: src/sfl_checker.sv
// ----------------------------------------------------------------------------
// Slab allocator port checker
// Timing relations between request, busy, done and configuration handshakes, and result addresses.
// ----------------------------------------------------------------------------
module sfl_checker
    import sfl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result,
    input logic cfg_ready
);

    // An accepted request keeps the block busy for exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 !busy)
    else $error("accepted request did not execute for one cycle");

    // A result only follows the execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

    // Every execute cycle produces exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
    else $error("execute cycle produced no result");

    // A refused request never reports an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.object_address == '0))
    else $error("refused request carries an address");

    // Configuration is held off while a request executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
    else $error("configuration accepted during execution");

endmodule

bind slab_free_list_allocator sfl_checker u_sfl_checker (.*);
